// ===== design/assert_macros.svh =====
// assertion helpers used by the tracker top design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, disabled during reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== design/fbrt_pkg.sv =====
package fbrt_pkg;

  // command codes
  localparam logic [1:0] CMD_REGISTER = 2'd0;
  localparam logic [1:0] CMD_SET_FENCE = 2'd1;
  localparam logic [1:0] CMD_RELEASE = 2'd2;
  localparam logic [1:0] CMD_DRAIN = 2'd3;

  // status codes
  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_INVALID_ARG = 3'd1;
  localparam logic [2:0] ST_OUT_OF_MEMORY = 3'd2;
  localparam logic [2:0] ST_DOUBLE_RELEASE = 3'd3;
  localparam logic [2:0] ST_INVALID_STATE = 3'd4;
  localparam logic [2:0] ST_NOT_FOUND = 3'd5;

  // entry flag bits
  localparam int FLAG_FENCE_SET = 0;
  localparam int FLAG_PENDING = 1;
  localparam int FLAG_RELEASED = 2;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] buf_handle;
    logic [31:0] size_bytes;
    logic [31:0] scope_tag;
    logic [31:0] fence_val;
    logic [31:0] drain_upto;
    logic [31:0] current_epoch;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] assigned_id;
    logic [31:0] double_release_total;
  } out_t;

  // one table record as held in the entry memory
  typedef struct packed {
    logic [2:0]  flags;
    logic [31:0] fence;
  } entry_t;

endpackage

// ===== design/fbrt_ram.sv =====
module fbrt_ram #(
  parameter int WIDTH = 35,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== design/fenced_buffer_release_tracker_top.sv =====
// Fenced buffer release tracker.
// Commands enter on in_data when start is high and busy is low; each command
// returns exactly one word on out_data, marked by a one-cycle out_valid.
// The receiver cannot stall: every result is taken in the cycle it shows.
// Entries are handed out in order and never reused, so entry k always holds
// buffer id k+1; a fill count marks the live entries and set-fence or release
// goes straight to entry id-1 through the entry memory's single read port.
// Steps, start accept to out_valid:
//   register, invalid arguments, unknown ids: result in the next cycle, busy stays low
//   set fence, release: memory read, then decide and write back
//   drain on an empty table: as register; else one entry read per cycle
//     from the shared memory port, with the check and write-back of each
//     entry in the cycle after its read
// Throughput: busy drops in the cycle a result shows, so the next command can
// be taken then; register and early errors allow one command per cycle.
// One epoch comparator serves both the release and the drain checks.
// Synchronous reset (rst_n low) empties the table, restarts ids at one and
// clears the double release count; the entry memory itself is not cleared.
`include "assert_macros.svh"

module fenced_buffer_release_tracker_top #(
  parameter int TABLE_ENTRIES = 64
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  fbrt_pkg::in_t  in_data,
  output logic           out_valid,
  output fbrt_pkg::out_t out_data
);

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam int ENT_W = $bits(fbrt_pkg::entry_t);
  localparam logic [CNT_W-1:0] FULL = CNT_W'(TABLE_ENTRIES);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_EXEC  = 3'b010,
    S_DRAIN = 3'b100
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic [31:0]      dr_cnt_r, dr_cnt_nxt;
  logic [CNT_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic             vld_r, vld_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [1:0]       cmd_r, cmd_nxt;
  logic [31:0]      now_r, now_nxt;
  logic             out_valid_r, out_valid_nxt;
  fbrt_pkg::out_t   out_data_r, out_data_nxt;

  logic             we;
  logic [IDX_W-1:0] waddr;
  fbrt_pkg::entry_t wentry;
  logic [IDX_W-1:0] raddr;
  logic [ENT_W-1:0] rdata;
  fbrt_pkg::entry_t rentry;
  logic [31:0]      id_m1;
  logic             id_known;
  logic [31:0]      dr_inc;
  logic             fence_ahead;

  assign rentry = fbrt_pkg::entry_t'(rdata);
  assign id_m1 = in_data.buf_handle - 32'd1;
  assign id_known = (in_data.buf_handle <= 32'(fill_r));
  assign dr_inc = (dr_cnt_r == 32'hFFFF_FFFF) ? dr_cnt_r : dr_cnt_r + 32'd1;
  // shared epoch compare: release epoch or drain limit against the stored fence
  assign fence_ahead = (now_r < rentry.fence);

  // entry memory: fence and flags per record
  fbrt_ram #(
    .WIDTH(ENT_W),
    .DEPTH(TABLE_ENTRIES)
  ) u_entries (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(ENT_W'(wentry)),
    .raddr(raddr),
    .rdata(rdata)
  );

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    dr_cnt_nxt    = dr_cnt_r;
    rd_ptr_nxt    = rd_ptr_r;
    vld_nxt       = 1'b0;
    idx_nxt       = idx_r;
    cmd_nxt       = cmd_r;
    now_nxt       = now_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    we            = 1'b0;
    waddr         = idx_r;
    wentry        = rentry;
    raddr         = id_m1[IDX_W-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd_nxt     = in_data.cmd;
          now_nxt     = in_data.current_epoch;
          idx_nxt     = id_m1[IDX_W-1:0];
          out_data_nxt.status = fbrt_pkg::ST_OK;
          out_data_nxt.assigned_id = 32'd0;
          out_data_nxt.double_release_total = dr_cnt_r;
          unique case (in_data.cmd) inside
            fbrt_pkg::CMD_REGISTER: begin
              out_valid_nxt = 1'b1;
              if (in_data.size_bytes == 32'd0) begin
                out_data_nxt.status = fbrt_pkg::ST_INVALID_ARG;
              end else if (fill_r == FULL) begin
                out_data_nxt.status = fbrt_pkg::ST_OUT_OF_MEMORY;
              end else begin
                we     = 1'b1;
                waddr  = fill_r[IDX_W-1:0];
                wentry = '0;
                fill_nxt = fill_r + CNT_W'(1);
                out_data_nxt.assigned_id = 32'(fill_r) + 32'd1;
              end
            end
            fbrt_pkg::CMD_SET_FENCE, fbrt_pkg::CMD_RELEASE: begin
              if (in_data.buf_handle == 32'd0 ||
                  (in_data.cmd == fbrt_pkg::CMD_SET_FENCE &&
                   in_data.fence_val == 32'd0)) begin
                out_valid_nxt = 1'b1;
                out_data_nxt.status = fbrt_pkg::ST_INVALID_ARG;
              end else if (!id_known) begin
                out_valid_nxt = 1'b1;
                out_data_nxt.status = fbrt_pkg::ST_NOT_FOUND;
              end else begin
                now_nxt   = (in_data.cmd == fbrt_pkg::CMD_SET_FENCE) ?
                            in_data.fence_val : in_data.current_epoch;
                state_nxt = S_EXEC;
              end
            end
            default: begin
              // drain: now_r holds the drain limit for the shared compare
              now_nxt    = in_data.drain_upto;
              rd_ptr_nxt = '0;
              if (fill_r == '0) begin
                out_valid_nxt = 1'b1;
              end else begin
                state_nxt = S_DRAIN;
              end
            end
          endcase
        end
      end

      S_EXEC: begin
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
        if (rentry.flags[fbrt_pkg::FLAG_PENDING] ||
            rentry.flags[fbrt_pkg::FLAG_RELEASED]) begin
          dr_cnt_nxt = dr_inc;
          out_data_nxt.status = fbrt_pkg::ST_DOUBLE_RELEASE;
        end else if (cmd_r == fbrt_pkg::CMD_SET_FENCE) begin
          // now_r holds the new fence here
          we           = 1'b1;
          wentry.fence = now_r;
          wentry.flags[fbrt_pkg::FLAG_FENCE_SET] = 1'b1;
        end else if (!rentry.flags[fbrt_pkg::FLAG_FENCE_SET] ||
                     rentry.fence == 32'd0) begin
          out_data_nxt.status = fbrt_pkg::ST_INVALID_STATE;
        end else if (fence_ahead) begin
          we = 1'b1;
          wentry.flags[fbrt_pkg::FLAG_PENDING] = 1'b1;
        end else begin
          we = 1'b1;
          wentry.flags[fbrt_pkg::FLAG_RELEASED] = 1'b1;
        end
        out_data_nxt.double_release_total = dr_cnt_nxt;
      end

      S_DRAIN: begin
        raddr = rd_ptr_r[IDX_W-1:0];
        // issue the next read while the previous entry is checked
        if (rd_ptr_r != fill_r) begin
          rd_ptr_nxt = rd_ptr_r + CNT_W'(1);
          vld_nxt    = 1'b1;
          idx_nxt    = rd_ptr_r[IDX_W-1:0];
        end else begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
        if (vld_r && rentry.flags[fbrt_pkg::FLAG_PENDING] && !fence_ahead) begin
          we = 1'b1;
          wentry.flags[fbrt_pkg::FLAG_PENDING]  = 1'b0;
          wentry.flags[fbrt_pkg::FLAG_RELEASED] = 1'b1;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      dr_cnt_r    <= '0;
      rd_ptr_r    <= '0;
      vld_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      dr_cnt_r    <= dr_cnt_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      vld_r       <= vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // command and result word registers
  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    cmd_r      <= cmd_nxt;
    now_r      <= now_nxt;
    out_data_r <= out_data_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `ASSERT_NEXT(a_exec_one_cycle, clk, rst_n, state_r == S_EXEC, out_valid_r && state_r == S_IDLE)
  `ASSERT_IMPL(a_fill_bound, clk, rst_n, 1'b1, fill_r <= FULL)
  `ASSERT_IMPL(a_drain_ptr_bound, clk, rst_n, state_r == S_DRAIN, rd_ptr_r <= fill_r)

endmodule

// ===== test/fenced_buffer_release_tracker_top_tb.sv =====
`timescale 1ns / 1ps

module fenced_buffer_release_tracker_top_tb;

  localparam int TABLE_SIZE = 64;
  localparam int RANDOM_WORDS = 600;
  localparam int CALM_TAIL = 100;
  localparam int SETTLE_CYCLES = TABLE_SIZE + 16;

  // shadow of the release table, predicts one reply per accepted command
  class release_ledger;
    bit             live [TABLE_SIZE];
    logic [31:0]    buf_id [TABLE_SIZE];
    logic [31:0]    fence [TABLE_SIZE];
    logic [2:0]     flags [TABLE_SIZE];
    logic [31:0]    next_id;
    logic [31:0]    double_count;
    fbrt_pkg::out_t expected_replies [$];
    int             faults;
    int             checked;
    int             registered;
    int             oom_seen;
    int             deferred;

    function new();
      foreach (live[i]) live[i] = 1'b0;
      next_id = 32'd1;
      double_count = '0;
      faults = 0;
      checked = 0;
      registered = 0;
      oom_seen = 0;
      deferred = 0;
    endfunction

    function int lookup(logic [31:0] id);
      for (int i = 0; i < TABLE_SIZE; i++) begin
        if (live[i] && buf_id[i] == id) return i;
      end
      return -1;
    endfunction

    // saturating double release counter
    function void bump_double();
      if (double_count != '1) double_count++;
    endfunction

    function void note_command(fbrt_pkg::in_t c);
      fbrt_pkg::out_t r;
      int slot;
      r.status = fbrt_pkg::ST_OK;
      r.assigned_id = '0;
      slot = -1;
      case (c.cmd)
        fbrt_pkg::CMD_REGISTER: begin
          for (int i = 0; i < TABLE_SIZE; i++) begin
            if (!live[i] && slot < 0) slot = i;
          end
          if (c.size_bytes == '0) begin
            r.status = fbrt_pkg::ST_INVALID_ARG;
          end else if (slot < 0) begin
            r.status = fbrt_pkg::ST_OUT_OF_MEMORY;
            oom_seen++;
          end else begin
            if (next_id == '0) next_id = 32'd1;
            live[slot] = 1'b1;
            buf_id[slot] = next_id;
            fence[slot] = '0;
            flags[slot] = '0;
            r.assigned_id = next_id;
            next_id = next_id + 32'd1;
            registered++;
          end
        end
        fbrt_pkg::CMD_SET_FENCE, fbrt_pkg::CMD_RELEASE: begin
          if (c.buf_handle == '0 ||
              (c.cmd == fbrt_pkg::CMD_SET_FENCE && c.fence_val == '0)) begin
            r.status = fbrt_pkg::ST_INVALID_ARG;
          end else begin
            slot = lookup(c.buf_handle);
            if (slot < 0) begin
              r.status = fbrt_pkg::ST_NOT_FOUND;
            end else if (flags[slot][fbrt_pkg::FLAG_PENDING] ||
                         flags[slot][fbrt_pkg::FLAG_RELEASED]) begin
              bump_double();
              r.status = fbrt_pkg::ST_DOUBLE_RELEASE;
            end else if (c.cmd == fbrt_pkg::CMD_SET_FENCE) begin
              fence[slot] = c.fence_val;
              flags[slot][fbrt_pkg::FLAG_FENCE_SET] = 1'b1;
            end else if (!flags[slot][fbrt_pkg::FLAG_FENCE_SET] || fence[slot] == '0) begin
              r.status = fbrt_pkg::ST_INVALID_STATE;
            end else if (c.current_epoch < fence[slot]) begin
              flags[slot][fbrt_pkg::FLAG_PENDING] = 1'b1;
              deferred++;
            end else begin
              flags[slot][fbrt_pkg::FLAG_RELEASED] = 1'b1;
            end
          end
        end
        default: begin
          // drain completes every pending buffer whose fence has passed
          for (int i = 0; i < TABLE_SIZE; i++) begin
            if (live[i] && flags[i][fbrt_pkg::FLAG_PENDING] &&
                c.drain_upto >= fence[i]) begin
              flags[i][fbrt_pkg::FLAG_PENDING] = 1'b0;
              flags[i][fbrt_pkg::FLAG_RELEASED] = 1'b1;
            end
          end
        end
      endcase
      r.double_release_total = double_count;
      expected_replies.push_back(r);
    endfunction

    function void check_response(fbrt_pkg::out_t got);
      fbrt_pkg::out_t want;
      if (expected_replies.size() == 0) begin
        faults++;
        if (faults <= 10) $display("tb: unexpected reply %h with nothing outstanding", got);
        return;
      end
      want = expected_replies.pop_front();
      checked++;
      if (got.status !== want.status || got.assigned_id !== want.assigned_id ||
          got.double_release_total !== want.double_release_total) begin
        faults++;
        if (faults <= 10) begin
          $display("tb: reply %0d mismatch: status %0d/%0d id %h/%h doubles %h/%h (exp/got)",
                   checked, want.status, got.status, want.assigned_id, got.assigned_id,
                   want.double_release_total, got.double_release_total);
        end
      end
    endfunction
  endclass

  logic           clk = 1'b0;
  logic           rst_n;
  logic           start;
  logic           busy;
  fbrt_pkg::in_t  in_data;
  logic           out_valid;
  fbrt_pkg::out_t out_data;

  release_ledger ledger;

  fenced_buffer_release_tracker_top #(
    .TABLE_ENTRIES(TABLE_SIZE)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // reply check first, so a reply is never matched against a word taken the same edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) ledger.check_response(out_data);
      if (start && !busy) ledger.note_command(in_data);
    end
  end

  function automatic fbrt_pkg::in_t noise_word();
    fbrt_pkg::in_t c;
    c.cmd = 2'($urandom);
    c.buf_handle = $urandom;
    c.size_bytes = $urandom;
    c.scope_tag = $urandom;
    c.fence_val = $urandom;
    c.drain_upto = $urandom;
    c.current_epoch = $urandom;
    return c;
  endfunction

  function automatic fbrt_pkg::in_t cmd_word(logic [1:0] cmd, logic [31:0] id,
                                             logic [31:0] len, logic [31:0] scope,
                                             logic [31:0] fnc, logic [31:0] through,
                                             logic [31:0] now);
    fbrt_pkg::in_t c;
    c.cmd = cmd;
    c.buf_handle = id;
    c.size_bytes = len;
    c.scope_tag = scope;
    c.fence_val = fnc;
    c.drain_upto = through;
    c.current_epoch = now;
    return c;
  endfunction

  // mostly live buffers, some unknown, a few wild or zero
  function automatic logic [31:0] pick_buffer();
    logic [31:0] issued;
    int roll;
    issued = ledger.next_id - 32'd1;
    if (issued == '0) issued = 32'd1;
    roll = $urandom_range(0, 99);
    if (roll < 75) return $urandom_range(1, issued);
    if (roll < 85) return $urandom_range(issued + 1, issued + 8);
    if (roll < 93) return $urandom;
    return '0;
  endfunction

  // small epochs so fences, releases and drains interact
  function automatic logic [31:0] pick_epoch(int lo);
    if ($urandom_range(0, 9) < 8) return $urandom_range(lo, 200);
    return $urandom;
  endfunction

  function automatic fbrt_pkg::in_t random_command();
    fbrt_pkg::in_t c;
    int roll;
    c = noise_word();
    roll = $urandom_range(0, 99);
    if (roll < 15) c.cmd = fbrt_pkg::CMD_REGISTER;
    else if (roll < 45) c.cmd = fbrt_pkg::CMD_SET_FENCE;
    else if (roll < 82) c.cmd = fbrt_pkg::CMD_RELEASE;
    else c.cmd = fbrt_pkg::CMD_DRAIN;
    c.buf_handle = pick_buffer();
    if ($urandom_range(0, 19) == 0) c.size_bytes = '0;
    if ($urandom_range(0, 9) == 0) c.scope_tag = '0;
    c.fence_val = ($urandom_range(0, 19) == 0) ? 32'd0 : pick_epoch(1);
    c.drain_upto = pick_epoch(0);
    c.current_epoch = pick_epoch(0);
    return c;
  endfunction

  // present one word and hold it until the block takes it
  task automatic push_command(input fbrt_pkg::in_t c);
    @(negedge clk);
    start <= 1'b1;
    in_data <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic hold_off(input int cycles);
    @(negedge clk);
    start <= 1'b0;
    in_data <= noise_word();
    repeat (cycles - 1) @(negedge clk);
  endtask

  initial begin
    ledger = new();
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // argument errors and lookups on an empty table
    push_command(cmd_word(fbrt_pkg::CMD_REGISTER, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0));
    push_command(cmd_word(fbrt_pkg::CMD_SET_FENCE, 32'd0, 32'd0, 32'd0, 32'd9, 32'd0, 32'd0));
    push_command(cmd_word(fbrt_pkg::CMD_RELEASE, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0));
    push_command(cmd_word(fbrt_pkg::CMD_RELEASE, 32'd5, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0));
    push_command(cmd_word(fbrt_pkg::CMD_SET_FENCE, '1, 32'd0, 32'd0, 32'd3, 32'd0, 32'd0));
    push_command(cmd_word(fbrt_pkg::CMD_DRAIN, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0));
    // registers with extreme length and scope
    push_command(cmd_word(fbrt_pkg::CMD_REGISTER, '1, '1, '1, '1, '1, '1));
    push_command(cmd_word(fbrt_pkg::CMD_REGISTER, 32'd0, 32'd1, 32'd0, 32'd0, 32'd0, 32'd0));
    push_command(cmd_word(fbrt_pkg::CMD_REGISTER, 32'd0, 32'd7, 32'h1234, 32'd0, 32'd0,
                          32'd0));
    // release before any fence, zero fence, then fence overwrite
    push_command(cmd_word(fbrt_pkg::CMD_RELEASE, 32'd1, 32'd0, 32'd0, 32'd0, 32'd0, '1));
    push_command(cmd_word(fbrt_pkg::CMD_SET_FENCE, 32'd1, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0));
    push_command(cmd_word(fbrt_pkg::CMD_SET_FENCE, 32'd1, 32'd0, 32'd0, 32'd10, 32'd0, 32'd0));
    push_command(cmd_word(fbrt_pkg::CMD_SET_FENCE, 32'd1, 32'd0, 32'd0, '1, 32'd0, 32'd0));
    // deferred release, then touches of a pending buffer
    push_command(cmd_word(fbrt_pkg::CMD_RELEASE, 32'd1, 32'd0, 32'd0, 32'd0, 32'd0, 32'd5));
    push_command(cmd_word(fbrt_pkg::CMD_RELEASE, 32'd1, 32'd0, 32'd0, 32'd0, 32'd0, 32'd5));
    push_command(cmd_word(fbrt_pkg::CMD_SET_FENCE, 32'd1, 32'd0, 32'd0, 32'd4, 32'd0, 32'd0));
    // drain short of the fence, then at the top epoch
    push_command(cmd_word(fbrt_pkg::CMD_DRAIN, 32'd1, 32'd1, 32'd1, 32'd1, 32'd100, 32'd1));
    push_command(cmd_word(fbrt_pkg::CMD_DRAIN, 32'd0, 32'd0, 32'd0, 32'd0, '1, 32'd0));
    push_command(cmd_word(fbrt_pkg::CMD_RELEASE, 32'd1, 32'd0, 32'd0, 32'd0, 32'd0, '1));
    // release exactly at the fence, and a fence of one
    push_command(cmd_word(fbrt_pkg::CMD_SET_FENCE, 32'd2, 32'd0, 32'd0, 32'd20, 32'd0, 32'd0));
    push_command(cmd_word(fbrt_pkg::CMD_RELEASE, 32'd2, 32'd0, 32'd0, 32'd0, 32'd0, 32'd20));
    push_command(cmd_word(fbrt_pkg::CMD_SET_FENCE, 32'd2, 32'd0, 32'd0, 32'd20, 32'd0, 32'd0));
    push_command(cmd_word(fbrt_pkg::CMD_SET_FENCE, 32'd3, 32'd0, 32'd0, 32'd1, 32'd0, 32'd0));
    push_command(cmd_word(fbrt_pkg::CMD_RELEASE, 32'd3, 32'd0, 32'd0, 32'd0, 32'd0, '1));

    // random traffic, idle bursts except in the tail
    for (int k = 0; k < RANDOM_WORDS; k++) begin
      push_command(random_command());
      if (k < RANDOM_WORDS - CALM_TAIL && $urandom_range(0, 3) == 0) begin
        hold_off($urandom_range(1, 5));
      end
    end
    @(negedge clk);
    start <= 1'b0;

    while (ledger.expected_replies.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("tb: %0d replies checked; %0d buffers registered, %0d out-of-memory, %0d deferred",
             ledger.checked, ledger.registered, ledger.oom_seen, ledger.deferred);
    $display("tb: %0d double releases counted, %0d mismatches",
             ledger.double_count, ledger.faults);
    if (ledger.faults == 0 && ledger.expected_replies.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+design
design/fbrt_pkg.sv
design/fbrt_ram.sv
design/fenced_buffer_release_tracker_top.sv
test/fenced_buffer_release_tracker_top_tb.sv
